// File: rtl/blm_pkg.sv
`default_nettype none
package blm_pkg;

	// Fixed field widths
	localparam int MV_BITS    = 13;
	localparam int PCT_W      = 7;
	localparam int SPR_W      = 5;
	localparam int STEP_W     = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	// Default longest round
	localparam int MAX_ROUND_SAMPLES_DEF = 16;

	// Register map
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_ROUND = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_MV          = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FULL_MV           = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_MV         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_CHANGE_MV     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SAVING_BELOW_PCT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SAVING_MARGIN_PCT = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_GLITCH_MODE       = 3'd7;

	// Register reset values
	localparam logic [SPR_W-1:0]   RST_SAMPLES_PER_ROUND = 5'd4;
	localparam logic [MV_BITS-1:0] RST_EMPTY_MV          = 13'd3300;
	localparam logic [MV_BITS-1:0] RST_FULL_MV           = 13'd4150;
	localparam logic [MV_BITS-1:0] RST_CHARGE_MV         = 13'd4200;
	localparam logic [STEP_W-1:0]  RST_MIN_CHANGE_MV     = 10'd20;
	localparam logic [PCT_W-1:0]   RST_SAVING_BELOW_PCT  = 7'd10;
	localparam logic [PCT_W-1:0]   RST_SAVING_MARGIN_PCT = 7'd5;

	// Glitch rule and fallback voltages in mV
	localparam logic [MV_BITS-1:0] JUMP_MV      = 13'd600;
	localparam logic [MV_BITS-1:0] GLITCH_OK_MV = 13'd3300;
	localparam logic [MV_BITS-1:0] FALLBACK_MV  = 13'd4123;

	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

	typedef struct packed {
		logic [SPR_W-1:0]   samples_per_round;
		logic [MV_BITS-1:0] empty_mv;
		logic [MV_BITS-1:0] full_mv;
		logic [MV_BITS-1:0] charge_mv;
		logic [STEP_W-1:0]  min_change_mv;
		logic [PCT_W-1:0]   saving_below_pct;
		logic [PCT_W-1:0]   saving_margin_pct;
		logic               glitch_mode;
	} cfg_t;

endpackage
`default_nettype wire

// File: rtl/blm_cfg.sv
`default_nettype none
module blm_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [blm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [blm_pkg::CFG_DATA_W-1:0] cfg_data,
	output blm_pkg::cfg_t                       cfg
);
	import blm_pkg::*;

	cfg_t cfg_q;

	// Always take a write word
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Decode index and update one register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.samples_per_round <= RST_SAMPLES_PER_ROUND;
			cfg_q.empty_mv          <= RST_EMPTY_MV;
			cfg_q.full_mv           <= RST_FULL_MV;
			cfg_q.charge_mv         <= RST_CHARGE_MV;
			cfg_q.min_change_mv     <= RST_MIN_CHANGE_MV;
			cfg_q.saving_below_pct  <= RST_SAVING_BELOW_PCT;
			cfg_q.saving_margin_pct <= RST_SAVING_MARGIN_PCT;
			cfg_q.glitch_mode       <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SAMPLES_PER_ROUND: cfg_q.samples_per_round <= cfg_data[SPR_W-1:0];
				CFG_EMPTY_MV:          cfg_q.empty_mv          <= cfg_data[MV_BITS-1:0];
				CFG_FULL_MV:           cfg_q.full_mv           <= cfg_data[MV_BITS-1:0];
				CFG_CHARGE_MV:         cfg_q.charge_mv         <= cfg_data[MV_BITS-1:0];
				CFG_MIN_CHANGE_MV:     cfg_q.min_change_mv     <= cfg_data[STEP_W-1:0];
				CFG_SAVING_BELOW_PCT:  cfg_q.saving_below_pct  <= cfg_data[PCT_W-1:0];
				CFG_SAVING_MARGIN_PCT: cfg_q.saving_margin_pct <= cfg_data[PCT_W-1:0];
				CFG_GLITCH_MODE:       cfg_q.glitch_mode       <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/blm_div.sv
`default_nettype none
module blm_div #(
	parameter int NUM_W = 20,
	parameter int DEN_W = 13
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic      [NUM_W-1:0] quo
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fits;

	// One restoring step: shift in the next numerator bit and try the divisor
	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		fits  = trial >= {1'b0, den_q};
	end

	// Sequence the steps, pulse done after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

// File: rtl/battery_level_monitor_unit.sv
`default_nettype none
// Battery level monitor. Each input word carries one millivolt sample; samples
// are summed over a round of samples_per_round words (0 acts as 1, values above
// MAX_ROUND_SAMPLES are clipped) and the round ends with one result word holding
// the truncated mean, the battery percentage, the charging and power-saving
// flags. With glitch_mode set, a zero sample or a jump of more than 600 mV ends
// the round early with the partial mean (previous sample above 3300 mV) or the
// last good voltage. Status is recomputed only when the mean moves by more than
// min_change_mv or force_update is set. in_ready is high only while the block
// is idle. A sample that does not end a round returns the block to idle after S_EVAL.
// A round end runs one shared bit-serial divider for the mean, unless the last good
// voltage is reused, and may run it again for the percentage when status is
// recomputed (divider width NUM_W is 20 at the default sizes). A result may wait
// for the previous one to be taken. Configuration writes are taken every cycle.
module battery_level_monitor_unit #(
	parameter int MAX_ROUND_SAMPLES = blm_pkg::MAX_ROUND_SAMPLES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [blm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [blm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [blm_pkg::MV_BITS-1:0]    sample_mv,
	input  wire logic                           force_update,
	input  wire logic                           radio_busy,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic      [blm_pkg::MV_BITS-1:0]    voltage_mv,
	output logic      [blm_pkg::PCT_W-1:0]      percent,
	output logic                                charging,
	output logic                                saving,
	output logic                                status_updated,
	output logic                                used_fallback,
	output logic                                saving_left
);
	import blm_pkg::*;

	localparam int CNT_W  = $clog2(MAX_ROUND_SAMPLES + 1);
	localparam int SUM_W  = MV_BITS + CNT_W;
	localparam int PROD_W = MV_BITS + PCT_W;
	localparam int NUM_W  = SUM_W > PROD_W ? SUM_W : PROD_W;
	localparam int DEN_W  = MV_BITS;
	localparam logic [7:0] MAX8 = 8'(MAX_ROUND_SAMPLES);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_AVG  = 3'd2;
	localparam logic [2:0] S_STAT = 3'd3;
	localparam logic [2:0] S_PCT0 = 3'd4;
	localparam logic [2:0] S_PCT  = 3'd5;
	localparam logic [2:0] S_SAVE = 3'd6;
	localparam logic [2:0] S_OUT  = 3'd7;

	cfg_t cfg;

	logic [2:0]         state_q;
	logic [MV_BITS-1:0] sample_q;
	logic               force_q;
	logic               radio_q;
	logic [CNT_W-1:0]   count_q;
	logic [SUM_W-1:0]   sum_q;
	logic [MV_BITS-1:0] prior_q;
	logic [MV_BITS-1:0] last_good_q;
	logic [MV_BITS-1:0] reported_q;
	logic [PCT_W-1:0]   pct_q;
	logic               chg_q;
	logic               sav_q;
	logic [MV_BITS-1:0] v_q;
	logic               upd_q;
	logic               fb_q;
	logic               left_q;
	logic [MV_BITS-1:0] x_q;
	logic [MV_BITS-1:0] span_q;

	logic               out_valid_q;
	logic [MV_BITS-1:0] out_mv_q;
	logic [PCT_W-1:0]   out_pct_q;
	logic               out_chg_q;
	logic               out_sav_q;
	logic               out_upd_q;
	logic               out_fb_q;
	logic               out_left_q;

	logic [7:0]         spr8;
	logic [7:0]         lim8;
	logic [CNT_W-1:0]   limit;
	logic [MV_BITS-1:0] jump;
	logic               glitch;
	logic               keep_partial;
	logic [SUM_W-1:0]   new_sum;
	logic [CNT_W-1:0]   new_count;
	logic [MV_BITS-1:0] vdiff;
	logic               upd;

	logic               div_start;
	logic [NUM_W-1:0]   div_num;
	logic [DEN_W-1:0]   div_den;
	logic               div_done;
	logic [NUM_W-1:0]   div_quo;

	logic               out_free;
	logic [PCT_W:0]     pct_plus_margin;

	blm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	blm_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Round length, clipped to 1..MAX_ROUND_SAMPLES
	always_comb begin
		spr8 = 8'(cfg.samples_per_round);
		if (spr8 == 8'd0) begin
			lim8 = 8'd1;
		end else if (spr8 > MAX8) begin
			lim8 = MAX8;
		end else begin
			lim8 = spr8;
		end
		limit = lim8[CNT_W-1:0];
	end

	// Glitch test and running sum for the held sample
	always_comb begin
		jump         = (prior_q > sample_q) ? prior_q - sample_q : sample_q - prior_q;
		glitch       = cfg.glitch_mode &&
		               (((prior_q != '0) && (jump > JUMP_MV)) || (sample_q == '0));
		keep_partial = (prior_q > GLITCH_OK_MV) && (count_q != '0);
		new_sum      = sum_q + SUM_W'(sample_q);
		new_count    = count_q + 1'b1;
	end

	// Change test against the last reported voltage
	always_comb begin
		vdiff = (reported_q > v_q) ? reported_q - v_q : v_q - reported_q;
		upd   = (vdiff > MV_BITS'(cfg.min_change_mv)) || force_q;
	end

	// Feed the shared divider: round mean or scaled percentage
	always_comb begin
		div_start = 1'b0;
		div_num   = NUM_W'(new_sum);
		div_den   = DEN_W'(new_count);
		case (state_q)
			S_EVAL: begin
				if (glitch) begin
					div_start = keep_partial;
					div_num   = NUM_W'(sum_q);
					div_den   = DEN_W'(count_q);
				end else begin
					div_start = !(new_count < limit);
				end
			end
			S_PCT0: begin
				div_start = 1'b1;
				div_num   = NUM_W'({x_q, 6'b0}) + NUM_W'({x_q, 5'b0}) + NUM_W'({x_q, 2'b0});
				div_den   = span_q;
			end
			default: begin
			end
		endcase
	end

	assign out_free        = !out_valid_q || out_ready;
	assign pct_plus_margin = {1'b0, pct_q} + {1'b0, cfg.saving_margin_pct};
	assign in_ready        = (state_q == S_IDLE);

	// Sequencer with round and status state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			sum_q       <= '0;
			prior_q     <= '0;
			last_good_q <= FALLBACK_MV;
			reported_q  <= '0;
			pct_q       <= '0;
			chg_q       <= 1'b0;
			sav_q       <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (glitch) begin
						count_q <= '0;
						sum_q   <= '0;
						prior_q <= '0;
						if (keep_partial) begin
							state_q <= S_AVG;
						end else begin
							state_q <= S_STAT;
						end
					end else if (new_count < limit) begin
						count_q <= new_count;
						sum_q   <= new_sum;
						prior_q <= sample_q;
						state_q <= S_IDLE;
					end else begin
						count_q <= '0;
						sum_q   <= '0;
						prior_q <= '0;
						state_q <= S_AVG;
					end
				end
				S_AVG: begin
					if (div_done) begin
						last_good_q <= div_quo[MV_BITS-1:0];
						state_q     <= S_STAT;
					end
				end
				S_STAT: begin
					if (!upd) begin
						state_q <= S_OUT;
					end else begin
						reported_q <= v_q;
						chg_q      <= v_q >= cfg.charge_mv;
						if (cfg.full_mv <= cfg.empty_mv) begin
							pct_q   <= (v_q > cfg.empty_mv) ? PCT_FULL : '0;
							state_q <= S_SAVE;
						end else if (v_q <= cfg.empty_mv) begin
							pct_q   <= '0;
							state_q <= S_SAVE;
						end else begin
							state_q <= S_PCT0;
						end
					end
				end
				S_PCT0: begin
					state_q <= S_PCT;
				end
				S_PCT: begin
					if (div_done) begin
						pct_q   <= (div_quo > NUM_W'(PCT_FULL)) ? PCT_FULL : div_quo[PCT_W-1:0];
						state_q <= S_SAVE;
					end
				end
				S_SAVE: begin
					// Power-saving hysteresis
					if (!sav_q && (pct_q < cfg.saving_below_pct) && !radio_q) begin
						sav_q <= 1'b1;
					end else if (sav_q && (pct_plus_margin > {1'b0, cfg.saving_below_pct}) &&
					             !chg_q) begin
						sav_q <= 1'b0;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Per-item working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				sample_q <= sample_mv;
				force_q  <= force_update;
				radio_q  <= radio_busy;
				fb_q     <= 1'b0;
				upd_q    <= 1'b0;
				left_q   <= 1'b0;
			end
			S_EVAL: begin
				if (glitch && !keep_partial) begin
					v_q  <= last_good_q;
					fb_q <= 1'b1;
				end
			end
			S_AVG: begin
				if (div_done) begin
					v_q <= div_quo[MV_BITS-1:0];
				end
			end
			S_STAT: begin
				upd_q  <= upd;
				x_q    <= v_q - cfg.empty_mv;
				span_q <= cfg.full_mv - cfg.empty_mv;
			end
			S_SAVE: begin
				left_q <= sav_q && !(!sav_q) && (pct_plus_margin > {1'b0, cfg.saving_below_pct})
				          && !chg_q && upd_q;
			end
			default: begin
			end
		endcase
	end

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			out_mv_q   <= v_q;
			out_pct_q  <= pct_q;
			out_chg_q  <= chg_q;
			out_sav_q  <= sav_q;
			out_upd_q  <= upd_q;
			out_fb_q   <= fb_q;
			out_left_q <= left_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign voltage_mv     = out_mv_q;
	assign percent        = out_pct_q;
	assign charging       = out_chg_q;
	assign saving         = out_sav_q;
	assign status_updated = out_upd_q;
	assign used_fallback  = out_fb_q;
	assign saving_left    = out_left_q;

endmodule
`default_nettype wire

// File: rtl/blm_checker.sv
`default_nettype none
module blm_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic [blm_pkg::MV_BITS-1:0] sample_mv,
	input wire logic                        force_update,
	input wire logic                        radio_busy,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [blm_pkg::MV_BITS-1:0] voltage_mv,
	input wire logic [blm_pkg::PCT_W-1:0]   percent,
	input wire logic                        charging,
	input wire logic                        saving,
	input wire logic                        status_updated,
	input wire logic                        used_fallback,
	input wire logic                        saving_left
);
	import blm_pkg::*;

	// Hold a stalled sample word
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(sample_mv) && $stable(force_update) &&
			$stable(radio_busy))
		else $error("sample word changed while waiting");

	// Hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(voltage_mv) && $stable(percent) &&
			$stable(charging) && $stable(saving) && $stable(status_updated) &&
			$stable(used_fallback) && $stable(saving_left))
		else $error("result word changed while stalled");

	// Busy in the cycle after taking a sample
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample taken on back-to-back cycles");

	// Percentage stays clamped
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> percent <= PCT_FULL)
		else $error("percentage above full scale");

	// Leaving power saving needs a recompute and leaves saving off
	a_left_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saving_left |-> status_updated && !saving)
		else $error("saving_left without a recompute that turned saving off");

endmodule

bind battery_level_monitor_unit blm_checker u_blm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.sample_mv      (sample_mv),
	.force_update   (force_update),
	.radio_busy     (radio_busy),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.voltage_mv     (voltage_mv),
	.percent        (percent),
	.charging       (charging),
	.saving         (saving),
	.status_updated (status_updated),
	.used_fallback  (used_fallback),
	.saving_left    (saving_left)
);
`default_nettype wire

// File: bench/tb_battery_level_monitor_unit.sv
`timescale 1ns / 1ps
module tb_battery_level_monitor_unit;
	import blm_pkg::*;

	localparam int ROUND_CAP     = MAX_ROUND_SAMPLES_DEF;
	localparam int NUM_REGS      = 8;
	localparam int RANDOM_PHASES = 12;
	localparam int SETTLE_CYCLES = 64;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int CYCLE_LIMIT   = 1500000;

	typedef struct packed {
		logic [MV_BITS-1:0] mv;
		logic               force_upd;
		logic               radio;
	} sample_word_t;

	typedef struct packed {
		logic [MV_BITS-1:0] voltage_mv;
		logic [PCT_W-1:0]   percent;
		logic               charging;
		logic               saving;
		logic               status_updated;
		logic               used_fallback;
		logic               saving_left;
	} status_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [MV_BITS-1:0]    sample_mv = '0;
	logic                  force_update = 1'b0;
	logic                  radio_busy = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [MV_BITS-1:0]    voltage_mv;
	logic [PCT_W-1:0]      percent;
	logic                  charging;
	logic                  saving;
	logic                  status_updated;
	logic                  used_fallback;
	logic                  saving_left;

	battery_level_monitor_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample_mv     (sample_mv),
		.force_update  (force_update),
		.radio_busy    (radio_busy),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.voltage_mv    (voltage_mv),
		.percent       (percent),
		.charging      (charging),
		.saving        (saving),
		.status_updated(status_updated),
		.used_fallback (used_fallback),
		.saving_left   (saving_left)
	);

	// Pending samples and predicted status words
	sample_word_t sample_queue[$];
	status_word_t expected_status[$];

	int unsigned in_launched = 0;
	int unsigned in_accepted = 0;
	int unsigned input_gap = 0;
	int unsigned out_hold = 0;
	int unsigned cycle_count = 0;
	int unsigned failures = 0;
	int unsigned reg_writes = 0;
	int unsigned phases_run = 0;
	int unsigned words_seen = 0;
	int unsigned words_updated = 0;
	int unsigned words_fallback = 0;
	int unsigned words_left = 0;
	bit          no_idle = 1'b0;
	int          level_mv = 3700;

	// Predictor state at the block's widths
	cfg_t               mdl_settings;
	logic [SPR_W-1:0]   mdl_count = '0;
	logic [17:0]        mdl_sum = '0;
	logic [MV_BITS-1:0] mdl_prior = '0;
	logic [MV_BITS-1:0] mdl_last_good = FALLBACK_MV;
	logic [MV_BITS-1:0] mdl_reported = '0;
	logic [PCT_W-1:0]   mdl_pct = '0;
	logic               mdl_charging = 1'b0;
	logic               mdl_saving = 1'b0;

	// Clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Advance the predicted round state by one sample; queue a status word at round end
	task automatic predict_round_status(input logic [MV_BITS-1:0] s, input logic force_upd,
			input logic radio);
		int unsigned  limit;
		int unsigned  jump;
		int unsigned  delta;
		int unsigned  pct;
		logic [MV_BITS-1:0] v;
		logic         done;
		logic         fb;
		logic         upd;
		logic         left;
		status_word_t w;
		limit = mdl_settings.samples_per_round;
		if (limit == 0)
			limit = 1;
		if (limit > ROUND_CAP)
			limit = ROUND_CAP;
		done = 1'b0;
		fb = 1'b0;
		upd = 1'b0;
		left = 1'b0;
		v = '0;
		// a zero or a jump ends the round early without adding the sample
		if (mdl_settings.glitch_mode) begin
			jump = (mdl_prior > s) ? mdl_prior - s : s - mdl_prior;
			if ((mdl_prior != 0 && jump > JUMP_MV) || s == 0) begin
				done = 1'b1;
				if (mdl_prior > GLITCH_OK_MV && mdl_count != 0) begin
					v = MV_BITS'(mdl_sum / mdl_count);
					mdl_last_good = v;
				end else begin
					v = mdl_last_good;
					fb = 1'b1;
				end
			end
		end
		// accumulate and close the round once it is full
		if (!done) begin
			mdl_sum = mdl_sum + s;
			mdl_count = mdl_count + 1'b1;
			mdl_prior = s;
			if (mdl_count >= limit) begin
				done = 1'b1;
				v = MV_BITS'(mdl_sum / mdl_count);
				mdl_last_good = v;
			end
		end
		if (done) begin
			mdl_sum = '0;
			mdl_count = '0;
			mdl_prior = '0;
			// recompute status on a large enough move or when forced
			delta = (mdl_reported > v) ? mdl_reported - v : v - mdl_reported;
			if (delta > mdl_settings.min_change_mv || force_upd) begin
				upd = 1'b1;
				mdl_reported = v;
				if (mdl_settings.full_mv <= mdl_settings.empty_mv)
					pct = (v > mdl_settings.empty_mv) ? 100 : 0;
				else if (v <= mdl_settings.empty_mv)
					pct = 0;
				else begin
					pct = ((v - mdl_settings.empty_mv) * 100) /
						(mdl_settings.full_mv - mdl_settings.empty_mv);
					if (pct > 100)
						pct = 100;
				end
				mdl_pct = pct[PCT_W-1:0];
				mdl_charging = (v >= mdl_settings.charge_mv);
				if (!mdl_saving && pct < mdl_settings.saving_below_pct && !radio) begin
					mdl_saving = 1'b1;
				end else if (mdl_saving && !mdl_charging &&
						pct + mdl_settings.saving_margin_pct > mdl_settings.saving_below_pct) begin
					mdl_saving = 1'b0;
					left = 1'b1;
				end
			end
			w.voltage_mv = v;
			w.percent = mdl_pct;
			w.charging = mdl_charging;
			w.saving = mdl_saving;
			w.status_updated = upd;
			w.used_fallback = fb;
			w.saving_left = left;
			expected_status.push_back(w);
		end
	endtask

	// Count accepted samples and predict their effect
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			in_accepted++;
			predict_round_status(sample_mv, force_update, radio_busy);
		end
	end

	// Sample driver: hold until accepted, then idle or launch the next word
	always @(negedge clk) begin : sample_driver
		sample_word_t next_word;
		if (in_valid && in_accepted != in_launched) begin
			// hold the current word
		end else if (input_gap != 0) begin
			input_gap--;
			in_valid <= 1'b0;
		end else if (sample_queue.size() != 0) begin
			next_word = sample_queue.pop_front();
			in_valid <= 1'b1;
			sample_mv <= next_word.mv;
			force_update <= next_word.force_upd;
			radio_busy <= next_word.radio;
			in_launched++;
			input_gap = pick_gap();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Result back-pressure
	always @(negedge clk) begin
		if (out_hold != 0) begin
			out_hold--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				out_hold = pick_gap();
		end
	end

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endtask

	// Compare each result word with the oldest prediction
	always @(posedge clk) begin : status_monitor
		status_word_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (expected_status.size() == 0) begin
				$error("status word with no prediction waiting: voltage_mv %0d", voltage_mv);
				failures++;
			end else begin
				want = expected_status.pop_front();
				words_seen++;
				if (want.status_updated)
					words_updated++;
				if (want.used_fallback)
					words_fallback++;
				if (want.saving_left)
					words_left++;
				check_field("voltage_mv", want.voltage_mv, voltage_mv);
				check_field("percent", want.percent, percent);
				check_field("charging", want.charging, charging);
				check_field("saving", want.saving, saving);
				check_field("status_updated", want.status_updated, status_updated);
				check_field("used_fallback", want.used_fallback, used_fallback);
				check_field("saving_left", want.saving_left, saving_left);
			end
		end
	end

	task automatic push_sample(input logic [MV_BITS-1:0] mv, input logic force_upd,
			input logic radio);
		sample_word_t w;
		w.mv = mv;
		w.force_upd = force_upd;
		w.radio = radio;
		sample_queue.push_back(w);
	endtask

	// Write one register and mirror it into the predictor
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_SAMPLES_PER_ROUND: mdl_settings.samples_per_round = value[SPR_W-1:0];
			CFG_EMPTY_MV:          mdl_settings.empty_mv = value[MV_BITS-1:0];
			CFG_FULL_MV:           mdl_settings.full_mv = value[MV_BITS-1:0];
			CFG_CHARGE_MV:         mdl_settings.charge_mv = value[MV_BITS-1:0];
			CFG_MIN_CHANGE_MV:     mdl_settings.min_change_mv = value[STEP_W-1:0];
			CFG_SAVING_BELOW_PCT:  mdl_settings.saving_below_pct = value[PCT_W-1:0];
			CFG_SAVING_MARGIN_PCT: mdl_settings.saving_margin_pct = value[PCT_W-1:0];
			CFG_GLITCH_MODE:       mdl_settings.glitch_mode = value[0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Wait until all samples are taken and all status words have come, then let the block settle
	task automatic wait_idle();
		int unsigned waited;
		while (sample_queue.size() != 0 || (in_valid && in_accepted != in_launched))
			@(posedge clk);
		waited = 0;
		while (expected_status.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_status.size() != 0) begin
			$error("%0d predicted status words never arrived", expected_status.size());
			failures++;
			expected_status.delete();
		end
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		phases_run++;
	endtask

	// Pick new settings, with the extremes and the out-of-range round lengths now and then
	task automatic pick_settings(input bit every_reg);
		logic [CFG_IDX_W-1:0] idx;
		int unsigned          value;
		int unsigned          r;
		for (int i = 0; i < NUM_REGS; i++) begin
			idx = i[CFG_IDX_W-1:0];
			r = $urandom_range(0, 9);
			case (idx)
				CFG_SAMPLES_PER_ROUND:
					value = (r == 0) ? 0 : (r == 1) ? ROUND_CAP : (r == 2) ? $urandom_range(17, 31) :
						(r == 3) ? 1 : $urandom_range(1, 6);
				CFG_EMPTY_MV:
					value = (r == 0) ? 0 : (r == 1) ? 8191 : $urandom_range(3000, 3600);
				CFG_FULL_MV:
					value = (r == 0) ? 8191 : (r == 1) ? $urandom_range(1, 3300) :
						$urandom_range(3700, 4400);
				CFG_CHARGE_MV:
					value = (r == 0) ? 0 : (r == 1) ? 8191 : $urandom_range(3800, 4400);
				CFG_MIN_CHANGE_MV:
					value = (r == 0) ? 0 : (r == 1) ? 1023 : $urandom_range(0, 100);
				CFG_SAVING_BELOW_PCT:
					value = (r == 0) ? 0 : (r == 1) ? 100 : $urandom_range(0, 60);
				CFG_SAVING_MARGIN_PCT:
					value = (r == 0) ? 0 : (r == 1) ? 100 : $urandom_range(0, 30);
				default:
					value = (r < 7);
			endcase
			if (every_reg || $urandom_range(0, 1) == 1)
				write_reg(idx, value[CFG_DATA_W-1:0]);
		end
	endtask

	// Mostly smooth traces around a drifting level, the rest zeros, jumps and raw noise
	task automatic queue_random_samples(input int unsigned count);
		int          mv;
		int unsigned r;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				if ($urandom_range(0, 15) == 0)
					level_mv = $urandom_range(2600, 4600);
				else
					level_mv = level_mv + int'($urandom_range(0, 120)) - 60;
				mv = level_mv + int'($urandom_range(0, 240)) - 120;
			end else if (r < 88) begin
				mv = 0;
			end else if (r < 94) begin
				mv = ($urandom_range(0, 1) == 1) ? level_mv + int'($urandom_range(601, 1500)) :
					level_mv - int'($urandom_range(601, 1500));
			end else begin
				mv = $urandom_range(0, 8191);
			end
			if (mv < 1 && r < 80)
				mv = 1;
			if (mv < 0)
				mv = 0;
			if (mv > 8191)
				mv = 8191;
			push_sample(mv[MV_BITS-1:0], $urandom_range(0, 3) == 0, $urandom_range(0, 1) == 1);
		end
	endtask

	initial begin
		mdl_settings.samples_per_round = RST_SAMPLES_PER_ROUND;
		mdl_settings.empty_mv = RST_EMPTY_MV;
		mdl_settings.full_mv = RST_FULL_MV;
		mdl_settings.charge_mv = RST_CHARGE_MV;
		mdl_settings.min_change_mv = RST_MIN_CHANGE_MV;
		mdl_settings.saving_below_pct = RST_SAVING_BELOW_PCT;
		mdl_settings.saving_margin_pct = RST_SAVING_MARGIN_PCT;
		mdl_settings.glitch_mode = 1'b0;
		arst_n = 1'b0;
		repeat (11)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: one full-scale round
		repeat (4)
			push_sample(13'd8191, 1'b0, 1'b0);
		wait_idle();

		// single-sample rounds: radio blocks saving, no move, saving on then off
		write_reg(CFG_SAMPLES_PER_ROUND, 1);
		push_sample(13'd0, 1'b1, 1'b1);
		push_sample(13'd0, 1'b0, 1'b0);
		push_sample(13'd3300, 1'b1, 1'b0);
		push_sample(13'd4150, 1'b1, 1'b0);
		wait_idle();

		// glitch rule: zero first sample, partial mean, fallback after a low sample
		write_reg(CFG_SAMPLES_PER_ROUND, 4);
		write_reg(CFG_GLITCH_MODE, 1);
		push_sample(13'd0, 1'b0, 1'b0);
		push_sample(13'd4000, 1'b0, 1'b0);
		push_sample(13'd4100, 1'b0, 1'b0);
		push_sample(13'd0, 1'b1, 1'b0);
		push_sample(13'd3000, 1'b0, 1'b0);
		push_sample(13'd3900, 1'b1, 1'b0);
		push_sample(13'd3500, 1'b0, 1'b0);
		push_sample(13'd4200, 1'b1, 1'b1);
		wait_idle();

		// inverted span and a zero round length
		write_reg(CFG_FULL_MV, 3000);
		write_reg(CFG_SAMPLES_PER_ROUND, 0);
		write_reg(CFG_GLITCH_MODE, 0);
		push_sample(13'd3301, 1'b1, 1'b0);
		push_sample(13'd3300, 1'b1, 1'b0);
		wait_idle();

		// shorten the round below the count already taken
		write_reg(CFG_FULL_MV, 4150);
		write_reg(CFG_SAMPLES_PER_ROUND, CFG_DATA_W'(ROUND_CAP));
		repeat (3)
			push_sample(13'd3600, 1'b0, 1'b0);
		wait_idle();
		write_reg(CFG_SAMPLES_PER_ROUND, 2);
		push_sample(13'd3600, 1'b1, 1'b0);
		wait_idle();

		// random phases, each ending with the sender held until every word is back
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			no_idle = (p == 0) || ($urandom_range(0, 4) == 0);
			pick_settings(p == 0);
			queue_random_samples($urandom_range(130, 200));
			wait_idle();
		end

		$display("Drove %0d samples over %0d phases with %0d register writes",
			in_accepted, phases_run, reg_writes);
		$display("Checked %0d status words: %0d recomputed, %0d fallback, %0d left saving",
			words_seen, words_updated, words_fallback, words_left);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
